@@ hw/rtl/tbs_pkg.sv @@
// Shared types and constants for the tolerance binary search block.
// No dependencies; every other file in this folder imports it.
`timescale 1ns / 1ps

package tbs_pkg;

	// Fixed field widths of the words on the ports.
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 10;
	localparam int RANGE_W = 11;
	// Internal signed position width: holds -1 up to 2**IDX_W.
	localparam int POS_W   = IDX_W + 2;

	// Action codes carried by a request word.
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	// Reset value of the tolerance register.
	localparam logic [DATA_W-1:0] TOL_RESET = 32'd1;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	// Status from the shared compare unit to the sequencer.
	typedef struct packed {
		logic match;    // |entry - key| < tolerance
		logic greater;  // entry > key
	} cmp_res_t;

endpackage

@@ hw/rtl/tbs_table.sv @@
// Value table: single write port and one registered read port.
// Depends on tbs_pkg for the data width.
`timescale 1ns / 1ps

module tbs_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [tbs_pkg::DATA_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [tbs_pkg::DATA_W-1:0] rd_data
);
	import tbs_pkg::*;

	logic [DATA_W-1:0] mem [TABLE_DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/tbs_cmp.sv @@
// Shared compare unit: exact 33-bit difference, magnitude against tolerance.
// Depends on tbs_pkg for widths and the result struct.
`timescale 1ns / 1ps

module tbs_cmp (
	input  logic signed [tbs_pkg::DATA_W-1:0] entry,
	input  logic signed [tbs_pkg::DATA_W-1:0] key,
	input  logic        [tbs_pkg::DATA_W-1:0] tolerance,
	output tbs_pkg::cmp_res_t                 res
);
	import tbs_pkg::*;

	logic signed [DATA_W:0] entry_x;
	logic signed [DATA_W:0] key_x;
	logic signed [DATA_W:0] diff;
	logic        [DATA_W:0] mag;

	assign entry_x = (DATA_W + 1)'(entry);
	assign key_x   = (DATA_W + 1)'(key);
	assign diff    = entry_x - key_x;
	// The negation of the most negative difference still fits as unsigned.
	assign mag     = diff[DATA_W] ? unsigned'(-diff) : unsigned'(diff);

	always_comb begin
		res.match   = mag < {1'b0, tolerance};
		res.greater = !diff[DATA_W] && (diff != '0);
	end

endmodule

@@ hw/rtl/tbs_ctrl.sv @@
// Search sequencer: holds the range, drives table reads, owns the result register.
// Depends on tbs_pkg for the state type, codes and compare status.
`timescale 1ns / 1ps

module tbs_ctrl #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                action,
	input  logic signed [tbs_pkg::DATA_W-1:0]   data_value,
	input  logic        [tbs_pkg::IDX_W-1:0]    range_low,
	input  logic signed [tbs_pkg::RANGE_W-1:0]  range_high,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                found,
	output logic        [tbs_pkg::IDX_W-1:0]    position,
	input  tbs_pkg::cmp_res_t                   cmp,
	output logic signed [tbs_pkg::DATA_W-1:0]   key,
	output logic                                rd_en,
	output logic        [tbs_pkg::IDX_W-1:0]    rd_pos
);
	import tbs_pkg::*;

	localparam int IDX_MAX = (2 ** IDX_W) - 1;
	localparam int HI_MAX  = (TABLE_DEPTH - 1 < IDX_MAX) ? TABLE_DEPTH - 1 : IDX_MAX;
	localparam logic signed [POS_W-1:0] HI_MAX_P = POS_W'(HI_MAX);
	localparam logic signed [POS_W-1:0] ONE_P    = POS_W'(1);

	state_t state_q, state_d;

	logic signed [POS_W-1:0]  lo_q, hi_q, mid_q;
	logic signed [POS_W-1:0]  hi_ext, hi_sat, span, mid_calc;
	logic signed [DATA_W-1:0] key_q;
	logic                     res_found_q;
	logic [IDX_W-1:0]         res_pos_q;
	logic                     rsp_valid_q, found_q;
	logic [IDX_W-1:0]         position_q;
	logic                     accept, empty, slot_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	assign hi_ext   = POS_W'(range_high);
	assign hi_sat   = (hi_ext > HI_MAX_P) ? HI_MAX_P : hi_ext;
	assign empty    = hi_q < lo_q;
	assign span     = hi_q - lo_q;
	assign mid_calc = lo_q + (span >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_SEARCH) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (empty) begin
					state_d = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = cmp.match ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Range and key registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && action == ACT_SEARCH) begin
			key_q       <= data_value;
			lo_q        <= signed'({2'b00, range_low});
			hi_q        <= hi_sat;
			res_found_q <= 1'b0;
			res_pos_q   <= '0;
		end else if (state_q == ST_READ && !empty) begin
			mid_q <= mid_calc;
		end else if (state_q == ST_CMP) begin
			if (cmp.match) begin
				res_found_q <= 1'b1;
				res_pos_q   <= mid_q[IDX_W-1:0];
			end else if (cmp.greater) begin
				hi_q <= mid_q - ONE_P;
			end else begin
				lo_q <= mid_q + ONE_P;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			found_q    <= res_found_q;
			position_q <= res_pos_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign found     = found_q;
	assign position  = position_q;
	assign key       = key_q;
	assign rd_pos    = mid_calc[IDX_W-1:0];

endmodule

@@ hw/rtl/tolerance_binary_search.sv @@
// Top level of the tolerance binary search block: tolerance register and wiring.
// Depends on tbs_pkg, tbs_table, tbs_cmp and tbs_ctrl.
//
//   Channel   Handshake               Word contents
//   req       req_valid / req_stall   action, entry_index, data_value, range_low, range_high
//   rsp       rsp_valid / rsp_stall   found, position
//   cfg       cfg_write_en            cfg_write_data (tolerance, unsigned Q16.16)
//
// A write word updates the table at the clock edge that takes it.
// A search word makes P probes, where P is at most log2 of the searchable
// depth plus one (11 for 1024 entries); each probe uses the table read port
// and then the shared compare unit, and the search ends when a probe matches
// or the range runs out. req_stall is high from acceptance of a search until
// its result is loaded into the output register. The result register keeps
// its word under rsp_stall, and a new request is taken while it waits.
// Reset clears the sequencer, the output valid and sets the tolerance to one LSB;
// the table contents are undefined until written.
`timescale 1ns / 1ps

module tolerance_binary_search #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic                                action,
	input  logic        [tbs_pkg::IDX_W-1:0]    entry_index,
	input  logic signed [tbs_pkg::DATA_W-1:0]   data_value,
	input  logic        [tbs_pkg::IDX_W-1:0]    range_low,
	input  logic signed [tbs_pkg::RANGE_W-1:0]  range_high,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                found,
	output logic        [tbs_pkg::IDX_W-1:0]    position,
	input  logic                                cfg_write_en,
	input  logic        [tbs_pkg::DATA_W-1:0]   cfg_write_data
);
	import tbs_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [DATA_W-1:0]        tolerance_q;
	logic                     wr_en, rd_en;
	logic [IDX_W-1:0]         rd_pos;
	logic [DATA_W-1:0]        rd_data;
	logic signed [DATA_W-1:0] key;
	cmp_res_t                 cmp;

	// The user must write the tolerance register only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (cfg_write_en) begin
			tolerance_q <= cfg_write_data;
		end
	end

	// Writes beyond the table are dropped; a write, like any other word, is
	// taken only while the sequencer is idle and is stalled during a search.
	assign wr_en = req_valid && !req_stall && (action == ACT_WRITE) &&
		(32'(entry_index) < TABLE_DEPTH);

	tbs_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.AW         (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(AW'(entry_index)),
		.wr_data(data_value),
		.rd_en  (rd_en),
		.rd_addr(AW'(rd_pos)),
		.rd_data(rd_data)
	);

	tbs_cmp u_cmp (
		.entry    (signed'(rd_data)),
		.key      (key),
		.tolerance(tolerance_q),
		.res      (cmp)
	);

	tbs_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.data_value(data_value),
		.range_low (range_low),
		.range_high(range_high),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.found     (found),
		.position  (position),
		.cmp       (cmp),
		.key       (key),
		.rd_en     (rd_en),
		.rd_pos    (rd_pos)
	);

endmodule

@@ hw/rtl/tbs_checker.sv @@
// Port-level checks for the tolerance binary search block, bound to the top level.
// Depends on tbs_pkg for field widths and action codes.
`timescale 1ns / 1ps

module tbs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_stall,
	input logic                               action,
	input logic                               rsp_valid,
	input logic                               rsp_stall,
	input logic                               found,
	input logic [tbs_pkg::IDX_W-1:0]          position
);
	import tbs_pkg::*;

	// A waiting result word holds still.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(found) && $stable(position))
		else $error("result word changed while stalled");

	// A miss reports position zero.
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> position == '0)
		else $error("not-found result with non-zero position");

	// A search occupies the block for at least the next cycle.
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && action == ACT_SEARCH |=> req_stall)
		else $error("request taken right after a search was accepted");

	// A write never produces a result word.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && action == ACT_WRITE && !rsp_valid |=> !rsp_valid)
		else $error("result word appeared after a write");

endmodule

bind tolerance_binary_search tbs_checker u_tbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.action   (action),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.found    (found),
	.position (position)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for tolerance_binary_search: searches and table writes are
// predicted in order and each response word is compared with the oldest prediction.
// Depends on tbs_pkg and the tolerance_binary_search RTL.

module testbench;
	import tbs_pkg::*;

	localparam int     TABLE_DEPTH   = 1024;
	// Two copies of the table and the tolerance: one follows the words as they are
	// planned, the other follows the words as the block accepts them.
	localparam int     PLAN          = 0;
	localparam int     LIVE          = 1;
	localparam int     SETTLE_CYCLES = 30;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     PHASE_ITEMS   = 130;
	localparam longint TIMEOUT_NS    = 5_000_000;
	localparam longint VAL_MIN       = -64'sd2147483648;
	localparam longint VAL_MAX       = 64'sd2147483647;

	typedef struct packed {
		logic                      act;
		logic        [IDX_W-1:0]   idx;
		logic signed [DATA_W-1:0]  val;
		logic        [IDX_W-1:0]   lo;
		logic signed [RANGE_W-1:0] hi;
	} req_word_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] pos;
	} result_word_t;

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       req_valid      = 1'b0;
	logic                       req_stall;
	logic                       action         = ACT_WRITE;
	logic        [IDX_W-1:0]    entry_index    = '0;
	logic signed [DATA_W-1:0]   data_value     = '0;
	logic        [IDX_W-1:0]    range_low      = '0;
	logic signed [RANGE_W-1:0]  range_high     = '0;
	logic                       rsp_valid;
	logic                       rsp_stall      = 1'b0;
	logic                       found;
	logic        [IDX_W-1:0]    position;
	logic                       cfg_write_en   = 1'b0;
	logic        [DATA_W-1:0]   cfg_write_data = '0;

	logic signed [DATA_W-1:0] table_copy [2][TABLE_DEPTH];
	logic        [DATA_W-1:0] tol_copy [2];
	bit                       plan_written [TABLE_DEPTH];

	req_word_t    pending_words[$];
	result_word_t expected_results[$];

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	bit  pressure_armed = 1'b0;
	bit  pressure_taken;
	int  hold_left;
	int  mismatch_count = 0;

	req_word_t    offered_word;
	result_word_t prediction;
	result_word_t oldest_result;
	logic         live_clean;

	tolerance_binary_search #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.action        (action),
		.entry_index   (entry_index),
		.data_value    (data_value),
		.range_low     (range_low),
		.range_high    (range_high),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.found         (found),
		.position      (position),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	always #5 clk = ~clk;

	// Walks the probe sequence of one search over one copy of the table. On the
	// planning copy it also reports whether any probe lands on an unwritten entry.
	function automatic void walk_search(input int which, input logic signed [DATA_W-1:0] key,
			input int lo_in, input int hi_in, output logic hit, output logic [IDX_W-1:0] pos,
			output logic clean);
		int                       lo;
		int                       hi;
		int                       mid;
		logic signed [DATA_W-1:0] entry;
		logic signed [DATA_W:0]   diff;
		logic        [DATA_W:0]   mag;
		lo    = lo_in;
		hi    = hi_in;
		hit   = 1'b0;
		pos   = '0;
		clean = 1'b1;
		if (hi > TABLE_DEPTH - 1)
			hi = TABLE_DEPTH - 1;
		while (hi >= lo && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (which == PLAN && !plan_written[mid])
				clean = 1'b0;
			entry = table_copy[which][mid];
			// The difference is taken one bit wider so that it cannot wrap.
			diff  = $signed({entry[DATA_W-1], entry}) - $signed({key[DATA_W-1], key});
			mag   = diff[DATA_W] ? -diff : diff;
			if (mag < {1'b0, tol_copy[which]}) begin
				hit = 1'b1;
				pos = IDX_W'(mid);
			end else if (entry > key) begin
				hi = mid - 1;
			end else begin
				lo = mid + 1;
			end
		end
	endfunction

	// Queues a word for the driver. A search that would read an unwritten entry is
	// dropped, since the block's table holds nothing defined there.
	function automatic bit offer_word(input req_word_t w);
		logic             hit;
		logic [IDX_W-1:0] pos;
		logic             clean;
		if (w.act == ACT_WRITE) begin
			table_copy[PLAN][w.idx] = w.val;
			plan_written[w.idx]     = 1'b1;
			pending_words.push_back(w);
			return 1'b1;
		end
		walk_search(PLAN, w.val, int'(w.lo), int'(w.hi), hit, pos, clean);
		if (!clean)
			return 1'b0;
		pending_words.push_back(w);
		return 1'b1;
	endfunction

	// Fields that an action does not use still carry random bits.
	function automatic req_word_t write_word(input int i, input longint v);
		req_word_t w;
		w.act = ACT_WRITE;
		w.idx = IDX_W'(i);
		w.val = DATA_W'(v);
		w.lo  = IDX_W'($urandom);
		w.hi  = RANGE_W'(int'($urandom_range(TABLE_DEPTH)) - 1);
		return w;
	endfunction

	function automatic req_word_t search_word(input int lo, input int hi, input longint key);
		req_word_t w;
		w.act = ACT_SEARCH;
		w.idx = IDX_W'($urandom);
		w.val = DATA_W'(key);
		w.lo  = IDX_W'(lo);
		w.hi  = RANGE_W'(hi);
		return w;
	endfunction

	function automatic longint clip(input longint v);
		if (v < VAL_MIN)
			return VAL_MIN;
		if (v > VAL_MAX)
			return VAL_MAX;
		return v;
	endfunction

	// A search over positions up to top_idx. Keys mostly sit on or near an entry in
	// the range, so that the walk goes deep before it matches or runs out.
	function automatic void random_search(input int top_idx);
		int     lo;
		int     hi;
		int     p;
		int     pick;
		longint entry;
		longint key;
		pick = $urandom_range(99);
		if (pick < 10) begin
			lo = $urandom_range(top_idx);
			hi = int'($urandom_range(lo)) - 1;
		end else if (pick < 25) begin
			lo = 0;
			hi = top_idx;
		end else begin
			lo = $urandom_range(top_idx);
			hi = $urandom_range(top_idx, lo);
		end
		p     = (hi >= lo) ? int'($urandom_range(hi, lo)) : lo;
		entry = longint'(table_copy[PLAN][p]);
		pick  = $urandom_range(99);
		if (pick < 50)
			key = entry + longint'($urandom_range(6)) - 3;
		else if (pick < 75)
			key = entry + longint'($urandom_range(262144)) - 131072;
		else if (pick < 90)
			key = longint'($signed($urandom));
		else
			key = $urandom_range(1) ? VAL_MAX : VAL_MIN;
		void'(offer_word(search_word(lo, hi, clip(key))));
	endfunction

	// Most writes keep the table ascending; the rest put an arbitrary value anywhere.
	function automatic void random_write();
		int                  i;
		longint              lo_v;
		longint              hi_v;
		longint unsigned     r;
		longint              v;
		i = $urandom_range(TABLE_DEPTH - 1);
		if ($urandom_range(99) < 70) begin
			lo_v = (i > 0) ? longint'(table_copy[PLAN][i-1]) : VAL_MIN;
			hi_v = (i < TABLE_DEPTH - 1) ? longint'(table_copy[PLAN][i+1]) : VAL_MAX;
			r    = {$urandom, $urandom};
			v    = (hi_v < lo_v) ? lo_v : lo_v + longint'(r % longint'(hi_v - lo_v + 1));
		end else begin
			v = longint'($signed($urandom));
		end
		void'(offer_word(write_word(i, v)));
	endfunction

	// Waits until every word is taken and every result is in, then lets any write
	// still in flight settle before the next register write.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_tolerance(input logic [DATA_W-1:0] v);
		@(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		tol_copy[LIVE]  = v;
		tol_copy[PLAN]  = v;
	endtask

	task automatic run_phase(input logic [DATA_W-1:0] tol, input int send_pct,
			input int recv_pct, input bit squeeze);
		int n;
		write_tolerance(tol);
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		if (squeeze)
			pressure_armed = 1'b1;
		for (n = 0; n < PHASE_ITEMS; n++) begin
			if ($urandom_range(99) < 20)
				random_write();
			else
				random_search(TABLE_DEPTH - 1);
		end
		wait_drained();
	endtask

	// Driver: offers the next pending word, holds it while stalled, and runs the
	// prediction for every word at the edge where it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid   <= 1'b0;
			action      <= ACT_WRITE;
			entry_index <= '0;
			data_value  <= '0;
			range_low   <= '0;
			range_high  <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				if (offered_word.act == ACT_WRITE) begin
					table_copy[LIVE][offered_word.idx] = offered_word.val;
				end else begin
					walk_search(LIVE, offered_word.val, int'(offered_word.lo),
						int'(offered_word.hi), prediction.hit, prediction.pos, live_clean);
					expected_results.push_back(prediction);
				end
			end
			if (!req_valid || !req_stall) begin
				if (pending_words.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
					offered_word = pending_words.pop_front();
					req_valid   <= 1'b1;
					action      <= offered_word.act;
					entry_index <= offered_word.idx;
					data_value  <= offered_word.val;
					range_low   <= offered_word.lo;
					range_high  <= offered_word.hi;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// The one long hold-off, counted down in cycles once the pressure phase arms it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left      <= 0;
			pressure_taken <= 1'b0;
		end else if (pressure_armed && !pressure_taken) begin
			pressure_taken <= 1'b1;
			hold_left      <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each response word taken against the oldest prediction and
	// decides the stall for the next cycle, holding it while the hold-off runs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: expected no result, actual found=%0b position=%0d",
						$time, found, position);
					mismatch_count = mismatch_count + 1;
				end else begin
					oldest_result = expected_results.pop_front();
					if (found !== oldest_result.hit) begin
						$display("%0t: found expected %0b actual %0b",
							$time, oldest_result.hit, found);
						mismatch_count = mismatch_count + 1;
					end
					if (position !== oldest_result.pos) begin
						$display("%0t: position expected %0d actual %0d",
							$time, oldest_result.pos, position);
						mismatch_count = mismatch_count + 1;
					end
				end
			end
			if ((pressure_armed && !pressure_taken) || hold_left > 0) begin
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= (int'($urandom_range(99)) < recv_stall_pct);
			end
		end
	end

	initial begin
		longint acc;
		int     n;
		tol_copy[PLAN] = TOL_RESET;
		tol_copy[LIVE] = TOL_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words under the reset tolerance of one: extreme values, a
		// duplicate, exact hits, near misses by one, empty ranges and the last entry.
		void'(offer_word(write_word(0, VAL_MIN)));
		void'(offer_word(write_word(1, -65536)));
		void'(offer_word(write_word(2, 0)));
		void'(offer_word(write_word(3, 0)));
		void'(offer_word(write_word(4, 1)));
		void'(offer_word(write_word(5, 65536)));
		void'(offer_word(write_word(6, 64'sh7FFF_0000)));
		void'(offer_word(write_word(7, VAL_MAX)));
		void'(offer_word(write_word(TABLE_DEPTH - 1, VAL_MAX)));
		void'(offer_word(search_word(0, 7, 0)));
		void'(offer_word(search_word(0, 7, VAL_MIN)));
		void'(offer_word(search_word(0, 7, VAL_MAX)));
		void'(offer_word(search_word(0, 7, 32768)));
		void'(offer_word(search_word(0, 7, 1)));
		void'(offer_word(search_word(0, 7, VAL_MIN + 1)));
		void'(offer_word(search_word(0, -1, 0)));
		void'(offer_word(search_word(5, 4, 0)));
		void'(offer_word(search_word(3, 3, 0)));
		void'(offer_word(search_word(TABLE_DEPTH - 1, TABLE_DEPTH - 1, VAL_MAX)));
		void'(offer_word(search_word(TABLE_DEPTH - 1, TABLE_DEPTH - 1, 0)));
		wait_drained();

		// Fill the whole table in ascending order, with the odd duplicate, and
		// search the part already filled along the way.
		send_idle_pct  = 29;
		recv_stall_pct = 29;
		acc = VAL_MIN + longint'($urandom_range(1000));
		for (n = 0; n < TABLE_DEPTH; n++) begin
			void'(offer_word(write_word(n, acc)));
			if ($urandom_range(15) != 0)
				acc = acc + longint'($urandom_range(4194300));
			if ($urandom_range(7) == 0)
				random_search(n);
		end
		wait_drained();

		run_phase(32'd0, 0, 0, 1'b0);
		run_phase(32'hFFFF_FFFF, 64, 0, 1'b0);
		run_phase(32'd65536, 0, 64, 1'b0);
		run_phase(32'd1, 29, 29, 1'b0);
		run_phase(DATA_W'($urandom_range(4096, 1)), 0, 0, 1'b1);
		run_phase(DATA_W'($urandom), 29, 29, 1'b0);

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/tbs_pkg.sv
hw/rtl/tbs_table.sv
hw/rtl/tbs_cmp.sv
hw/rtl/tbs_ctrl.sv
hw/rtl/tolerance_binary_search.sv
hw/rtl/tbs_checker.sv
verif/testbench.sv
